// ----- sv/tcce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared constants, codes and types of the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int STORE_CELLS  = 16384;
   localparam int SCREEN_CELLS = COLUMNS * ROWS;

   localparam int ADDR_W    = $clog2(STORE_CELLS);
   localparam int OFS_W     = 14;
   localparam int COL_W     = $clog2(COLUMNS + 1);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int CELL_W    = 16;
   localparam int CHAR_W    = 8;
   localparam int CMD_W     = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [CHAR_W-1:0] ATTR_RESET  = 8'h07;
   localparam logic [CELL_W-1:0] BLANK_RESET = 16'h0720;

   // control bytes
   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
   localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
   localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
   localparam logic [CHAR_W-1:0] CH_HT  = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
   localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ATTR  = 1'b0,
      REG_BLANK = 1'b1
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_SCROLL,
      ST_CHAR
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [CELL_W-1:0] wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic              valid;
      logic [CELL_W-1:0] cell_data;
      logic [OFS_W-1:0]  cursor_cell;
      logic [OFS_W-1:0]  display_start;
      logic              cursor_update;
   } rsp_type;

   function automatic logic in_store(input logic [OFS_W-1:0] ofs);
      return int'(ofs) < STORE_CELLS;
   endfunction

endpackage

// ----- sv/tcce_cell_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcce_cell_ram import tcce_pkg::*; (
   input  logic              clock,
   input  ram_req_type       req,
   output logic [CELL_W-1:0] rdata
);

   logic [CELL_W-1:0] mem [STORE_CELLS];
   logic [CELL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rdata_ff <= mem[req.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/tcce_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_seq
// Command sequencer: cursor state, byte decode, scroll, relocation and sweeps
// over the cell store.
// ----------------------------------------------------------------------------
module tcce_seq import tcce_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CMD_W-1:0]     command,
   input  logic [CHAR_W-1:0]    char_code,
   input  logic [OFS_W-1:0]     cell_index,
   input  logic                 end_of_write,
   input  logic [CHAR_W-1:0]    text_attribute,
   input  logic [CELL_W-1:0]    blank_cell,
   output logic                 busy,
   output ram_req_type          ram_req,
   input  logic [CELL_W-1:0]    ram_rdata,
   output rsp_type              rsp
);

   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [OFS_W-1:0]  cur_ff, cur_in;
   logic [OFS_W-1:0]  scr_ff, scr_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              pend_ff, pend_in;
   logic              upd_ff, upd_in;
   logic              clr_ff, clr_in;
   logic              rd_ok_ff, rd_ok_in;

   ram_req_type       req;
   rsp_type           rsp_c;
   logic              done;
   logic              upd_now;
   logic [CELL_W-1:0] data;
   logic [OFS_W-1:0]  base_cur;
   logic [COL_W-1:0]  base_col;
   logic              next_row;
   logic              wrap_char;
   logic              relocate;
   logic [OFS_W-1:0]  fill_ofs;
   logic [OFS_W-1:0]  copy_src;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         col_ff   <= '0;
         row_ff   <= '0;
         cur_ff   <= '0;
         scr_ff   <= '0;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         clr_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         cur_ff   <= cur_in;
         scr_ff   <= scr_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      upd_ff   <= upd_in;
      rd_ok_ff <= rd_ok_in;
   end

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      cur_in    = cur_ff;
      scr_in    = scr_ff;
      cnt_in    = cnt_ff;
      char_in   = char_ff;
      pend_in   = pend_ff;
      upd_in    = upd_ff;
      clr_in    = clr_ff;
      rd_ok_in  = rd_ok_ff;
      req       = '0;
      rsp_c     = '0;
      done      = 1'b0;
      upd_now   = upd_ff;
      data      = '0;
      base_cur  = cur_ff;
      base_col  = col_ff;
      next_row  = 1'b0;
      wrap_char = 1'b0;
      // scrolling one more row would reach or run past the end of the store
      relocate  = (int'(scr_ff) + SCREEN_CELLS + COLUMNS) >= STORE_CELLS;
      fill_ofs  = scr_ff + OFS_W'(SCREEN_CELLS) + OFS_W'(cnt_ff);
      copy_src  = scr_ff + OFS_W'(cnt_ff);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (command)
                  CMD_PUT: begin
                     upd_now = end_of_write;
                     upd_in  = end_of_write;
                     case (char_code) inside
                        CH_NUL, CH_BEL, CH_HT, CH_VT: begin
                           done = 1'b1;
                        end
                        CH_BS: begin
                           if (col_ff != '0) begin
                              col_in    = col_ff - COL_W'(1);
                              cur_in    = cur_ff - OFS_W'(1);
                              req.we    = in_store(cur_in);
                              req.waddr = cur_in[ADDR_W-1:0];
                              req.wdata = blank_cell;
                           end
                           done = 1'b1;
                        end
                        CH_CR: begin
                           cur_in = cur_ff - OFS_W'(col_ff);
                           col_in = '0;
                           done   = 1'b1;
                        end
                        CH_DEL: begin
                           req.we    = in_store(cur_ff);
                           req.waddr = cur_ff[ADDR_W-1:0];
                           req.wdata = blank_cell;
                           done      = 1'b1;
                        end
                        CH_LF: begin
                           base_cur = cur_ff - OFS_W'(col_ff);
                           base_col = '0;
                           next_row = 1'b1;
                        end
                        CH_FF: begin
                           next_row = 1'b1;
                        end
                        default: begin
                           if (int'(col_ff) >= COLUMNS) begin
                              base_cur  = cur_ff - OFS_W'(COLUMNS);
                              base_col  = col_ff - COL_W'(COLUMNS);
                              next_row  = 1'b1;
                              wrap_char = 1'b1;
                           end else begin
                              req.we    = in_store(cur_ff);
                              req.waddr = cur_ff[ADDR_W-1:0];
                              req.wdata = {text_attribute, char_code};
                              cur_in    = cur_ff + OFS_W'(1);
                              col_in    = col_ff + COL_W'(1);
                              done      = 1'b1;
                           end
                        end
                     endcase
                     if (next_row) begin
                        if (int'(row_ff) + 1 < ROWS) begin
                           row_in = row_ff + ROW_W'(1);
                           if (wrap_char) begin
                              // wrap lands on the cell right after the old row
                              req.we    = in_store(cur_ff);
                              req.waddr = cur_ff[ADDR_W-1:0];
                              req.wdata = {text_attribute, char_code};
                              cur_in    = cur_ff + OFS_W'(1);
                              col_in    = base_col + COL_W'(1);
                           end else begin
                              cur_in = base_cur + OFS_W'(COLUMNS);
                              col_in = base_col;
                           end
                           done = 1'b1;
                        end else begin
                           cur_in   = base_cur;
                           col_in   = base_col;
                           char_in  = char_code;
                           pend_in  = wrap_char;
                           cnt_in   = '0;
                           state_in = relocate ? ST_COPY : ST_SCROLL;
                        end
                     end
                  end
                  CMD_READ: begin
                     req.re    = 1'b1;
                     req.raddr = cell_index[ADDR_W-1:0];
                     rd_ok_in  = in_store(cell_index);
                     state_in  = ST_READ;
                  end
                  CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     cur_in   = '0;
                     scr_in   = '0;
                     cnt_in   = '0;
                     clr_in   = 1'b1;
                     upd_in   = 1'b1;
                     state_in = ST_FILL;
                  end
                  default: begin
                     upd_now = 1'b0;
                     done    = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            data     = rd_ok_ff ? ram_rdata : '0;
            upd_now  = 1'b0;
            done     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            // reset sweep uses the reset blank word, clear uses the register
            req.we    = 1'b1;
            req.waddr = cnt_ff;
            req.wdata = clr_ff ? blank_cell : BLANK_RESET;
            cnt_in    = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(STORE_CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
               done     = clr_ff;
               upd_now  = 1'b1;
               clr_in   = 1'b0;
            end
         end
         ST_COPY: begin
            // read runs one cell ahead of the write
            if (int'(cnt_ff) < SCREEN_CELLS) begin
               req.re    = 1'b1;
               req.raddr = copy_src[ADDR_W-1:0];
            end
            if (cnt_ff != '0) begin
               req.we    = 1'b1;
               req.waddr = cnt_ff - ADDR_W'(1);
               req.wdata = ram_rdata;
            end
            cnt_in = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(SCREEN_CELLS)) begin
               cur_in   = cur_ff - scr_ff;
               scr_in   = '0;
               cnt_in   = '0;
               state_in = ST_SCROLL;
            end
         end
         ST_SCROLL: begin
            req.we    = in_store(fill_ofs);
            req.waddr = fill_ofs[ADDR_W-1:0];
            req.wdata = blank_cell;
            cnt_in    = cnt_ff + ADDR_W'(1);
            if (cnt_ff == ADDR_W'(COLUMNS - 1)) begin
               scr_in = scr_ff + OFS_W'(COLUMNS);
               cur_in = cur_ff + OFS_W'(COLUMNS);
               cnt_in = '0;
               if (pend_ff) begin
                  state_in = ST_CHAR;
               end else begin
                  state_in = ST_IDLE;
                  done     = 1'b1;
               end
            end
         end
         ST_CHAR: begin
            req.we    = in_store(cur_ff);
            req.waddr = cur_ff[ADDR_W-1:0];
            req.wdata = {text_attribute, char_ff};
            cur_in    = cur_ff + OFS_W'(1);
            col_in    = col_ff + COL_W'(1);
            pend_in   = 1'b0;
            done      = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         rsp_c.valid         = 1'b1;
         rsp_c.cell_data     = data;
         rsp_c.cursor_cell   = cur_in;
         rsp_c.display_start = scr_in;
         rsp_c.cursor_update = upd_now;
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign ram_req = req;
   assign rsp     = rsp_c;

   // while idle, cursor offset agrees with screen start, row and column
   a_cursor_consistent: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |->
         int'(cur_ff) == int'(scr_ff) + int'(row_ff) * COLUMNS + int'(col_ff))
      else $error("cursor offset out of step with row and column");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !start) |-> !req.we)
      else $error("store written while idle");

   a_copy_no_collide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY && req.we && req.re) |-> req.waddr != req.raddr)
      else $error("copy reads and writes the same cell");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_c.valid |=> state_ff == ST_IDLE)
      else $error("result given without returning to idle");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      int'(row_ff) < ROWS && int'(col_ff) <= COLUMNS)
      else $error("cursor row or column out of range");

endmodule

// ----- sv/text_console_char_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine
// Text-mode console engine: cell store of attribute/character words, cursor
// and display start, driven by put, read and clear commands.
// ----------------------------------------------------------------------------
// Channel   Ports                                        Transfer
// command   start, busy, req_*                           start & !busy
// result    rsp_strobe, rsp_*                            rsp_strobe, one cycle
// config    csr_valid, csr_ready, csr_index, csr_wdata   csr_valid & csr_ready
//
// Ignored, editing and printable bytes and unused commands finish in idle; the
// result follows in the cycle after the transfer. A read passes through the
// read state (registered store read data). A scroll adds row blanking,
// relocation a copy of the screen to the store start, a wrapped byte a last
// write. Clear and the reset sweep cover the whole store with busy high;
// config writes are taken meanwhile. The result channel cannot stall.
// ----------------------------------------------------------------------------
module text_console_char_engine import tcce_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic [OFS_W-1:0]     req_cell_index,
   input  logic                 req_end_of_write,
   output logic                 rsp_strobe,
   output logic [CELL_W-1:0]    rsp_cell_data,
   output logic [OFS_W-1:0]     rsp_cursor_cell,
   output logic [OFS_W-1:0]     rsp_display_start,
   output logic                 rsp_cursor_update,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CELL_W-1:0]    csr_wdata
);

   logic [CHAR_W-1:0] attr_ff;
   logic [CELL_W-1:0] blank_ff;
   logic              strobe_ff;
   logic [CELL_W-1:0] data_ff;
   logic [OFS_W-1:0]  cursor_ff;
   logic [OFS_W-1:0]  start_ff;
   logic              update_ff;

   ram_req_type       ram_req;
   logic [CELL_W-1:0] ram_rdata;
   rsp_type           rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff  <= ATTR_RESET;
         blank_ff <= BLANK_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ATTR:  attr_ff  <= csr_wdata[CHAR_W-1:0];
            REG_BLANK: blank_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   tcce_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .command        (req_command),
      .char_code      (req_char_code),
      .cell_index     (req_cell_index),
      .end_of_write   (req_end_of_write),
      .text_attribute (attr_ff),
      .blank_cell     (blank_ff),
      .busy           (busy),
      .ram_req        (ram_req),
      .ram_rdata      (ram_rdata),
      .rsp            (rsp)
   );

   tcce_cell_ram u_ram (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= rsp.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp.valid) begin
         data_ff   <= rsp.cell_data;
         cursor_ff <= rsp.cursor_cell;
         start_ff  <= rsp.display_start;
         update_ff <= rsp.cursor_update;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_cell_data     = data_ff;
   assign rsp_cursor_cell   = cursor_ff;
   assign rsp_display_start = start_ff;
   assign rsp_cursor_update = update_ff;

endmodule

// ----- dv/text_console_char_engine_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_engine_test
// Self-checking bench for the console engine. A queue of commands feeds a
// falling-edge driver with random gaps. A rising-edge monitor runs a shadow
// console for every accepted command and checks each result strobe against it.
// The run has a directed opening and then three random phases under different
// attribute and blank settings. One phase is heavy on line feeds, so the
// screen runs off the end of the store and gets relocated.
// ----------------------------------------------------------------------------
module text_console_char_engine_test;
   import tcce_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int MAX_GAP = 12;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [CHAR_W-1:0] ch;
      logic [OFS_W-1:0]  idx;
      logic              eow;
      int                gap;
   } console_cmd;

   typedef struct packed {
      logic [CELL_W-1:0] cell_data;
      logic [OFS_W-1:0]  cursor_cell;
      logic [OFS_W-1:0]  display_start;
      logic              cursor_update;
   } console_view;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [CMD_W-1:0]     req_command = '0;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic [OFS_W-1:0]     req_cell_index = '0;
   logic                 req_end_of_write = 1'b0;
   logic                 rsp_strobe;
   logic [CELL_W-1:0]    rsp_cell_data;
   logic [OFS_W-1:0]     rsp_cursor_cell;
   logic [OFS_W-1:0]     rsp_display_start;
   logic                 rsp_cursor_update;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_reg_type          csr_index = REG_ATTR;
   logic [CELL_W-1:0]    csr_wdata = '0;

   text_console_char_engine dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_char_code     (req_char_code),
      .req_cell_index    (req_cell_index),
      .req_end_of_write  (req_end_of_write),
      .rsp_strobe        (rsp_strobe),
      .rsp_cell_data     (rsp_cell_data),
      .rsp_cursor_cell   (rsp_cursor_cell),
      .rsp_display_start (rsp_display_start),
      .rsp_cursor_update (rsp_cursor_update),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #4 clock = ~clock;

   // shadow console
   logic [CELL_W-1:0] shadow_cells [STORE_CELLS];
   int                col, row, cur_ofs, scr_ofs;
   logic [CHAR_W-1:0] attr_reg;
   logic [CELL_W-1:0] blank_reg;

   console_cmd  command_queue [$];
   console_view expected_views [$];
   logic        cmd_taken = 1'b0;
   bit          no_idle = 1'b0;
   int          idle_cycles = 0;
   int          queued = 0;
   int          fail_count = 0;
   int          commands_sent = 0, reads_sent = 0, clears_sent = 0;
   int          results_checked = 0, scroll_count = 0, relocation_count = 0;
   int          cycle_count = 0;
   int          cycle_limit = 4 * STORE_CELLS + 20000;

   function automatic void shadow_put(int ofs, logic [CELL_W-1:0] v);
      if (ofs >= 0 && ofs < STORE_CELLS) shadow_cells[ofs] = v;
   endfunction

   function automatic void shadow_fill();
      int i;
      for (i = 0; i < STORE_CELLS; i++) shadow_cells[i] = blank_reg;
   endfunction

   function automatic void advance_row();
      int i;
      if (row + 1 < ROWS) begin
         row++;
         cur_ofs += COLUMNS;
      end else begin
         // another row below the screen would reach or pass the end of the store: move the screen to the top
         if (!(scr_ofs + SCREEN_CELLS + COLUMNS < STORE_CELLS)) begin
            if (scr_ofs + SCREEN_CELLS <= STORE_CELLS)
               for (i = 0; i < SCREEN_CELLS; i++) shadow_cells[i] = shadow_cells[scr_ofs + i];
            cur_ofs -= scr_ofs;
            scr_ofs = 0;
            relocation_count++;
         end
         for (i = 0; i < COLUMNS; i++) shadow_put(scr_ofs + SCREEN_CELLS + i, blank_reg);
         scr_ofs += COLUMNS;
         cur_ofs += COLUMNS;
         scroll_count++;
      end
   endfunction

   function automatic console_view console_apply(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                                 logic [OFS_W-1:0] idx, logic eow);
      console_view v;
      v.cell_data = '0;
      v.cursor_update = 1'b0;
      case (cmd)
         CMD_PUT: begin
            case (ch)
               CH_NUL, CH_BEL, CH_HT, CH_VT: ;
               CH_BS: begin
                  if (col != 0) begin
                     col--;
                     cur_ofs--;
                     shadow_put(cur_ofs, blank_reg);
                  end
               end
               CH_LF: begin
                  cur_ofs -= col;
                  col = 0;
                  advance_row();
               end
               CH_FF: advance_row();
               CH_CR: begin
                  cur_ofs -= col;
                  col = 0;
               end
               CH_DEL: shadow_put(cur_ofs, blank_reg);
               default: begin
                  // deferred wrap: the row only breaks when the next byte lands
                  if (col >= COLUMNS) begin
                     col -= COLUMNS;
                     cur_ofs -= COLUMNS;
                     advance_row();
                  end
                  shadow_put(cur_ofs, {attr_reg, ch});
                  cur_ofs++;
                  col++;
               end
            endcase
            v.cursor_update = eow;
         end
         CMD_READ: begin
            reads_sent++;
            if (int'(idx) < STORE_CELLS) v.cell_data = shadow_cells[idx];
         end
         CMD_CLEAR: begin
            clears_sent++;
            scr_ofs = 0;
            cur_ofs = 0;
            col = 0;
            row = 0;
            shadow_fill();
            v.cursor_update = 1'b1;
         end
         default: ;
      endcase
      v.cursor_cell = OFS_W'(cur_ofs);
      v.display_start = OFS_W'(scr_ofs);
      return v;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void queue_item(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                      logic [OFS_W-1:0] idx, logic eow);
      console_cmd c;
      int         cost;
      if (queued % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
      c.cmd = cmd;
      c.ch = ch;
      c.idx = idx;
      c.eow = eow;
      c.gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      // a put may scroll, and now and then relocate the screen
      cost = (cmd == CMD_CLEAR) ? STORE_CELLS :
             (cmd == CMD_PUT) ? COLUMNS + 4 + SCREEN_CELLS / 150 : 4;
      cycle_limit += 4 * (c.gap + 8 + cost);
      command_queue.push_back(c);
      queued++;
   endfunction

   function automatic logic [CHAR_W-1:0] plain_byte();
      logic [CHAR_W-1:0] b;
      do b = 8'($urandom);
      while (b inside {CH_NUL, CH_BEL, CH_BS, CH_HT, CH_LF, CH_VT, CH_FF, CH_CR, CH_DEL});
      return b;
   endfunction

   // text lines with random content, mixed with edits, reads and noise
   task automatic gen_text(input int n, input int lf_pct, input int txt_pct, input bit clear_ok);
      int target, r, len, k;
      logic [CHAR_W-1:0] code;
      target = queued + n;
      while (queued < target) begin
         r = $urandom_range(0, 99);
         if (r < lf_pct) begin
            queue_item(CMD_PUT, ($urandom_range(0, 2) == 0) ? CH_FF : CH_LF,
                       14'($urandom), 1'($urandom));
         end else if (r < lf_pct + txt_pct) begin
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(COLUMNS - 4, COLUMNS + 10)
                                               : $urandom_range(1, 3);
            for (k = 0; k < len; k++)
               queue_item(CMD_PUT, plain_byte(), 14'($urandom), k == len - 1);
         end else if (r < lf_pct + txt_pct + 4) begin
            case ($urandom_range(0, 6))
               0: code = CH_BS;
               1: code = CH_DEL;
               2: code = CH_CR;
               3: code = CH_NUL;
               4: code = CH_BEL;
               5: code = CH_HT;
               default: code = CH_VT;
            endcase
            queue_item(CMD_PUT, code, 14'($urandom), 1'($urandom));
         end else if (r < lf_pct + txt_pct + 6) begin
            queue_item(CMD_UNUSED, 8'($urandom), 14'($urandom), 1'($urandom));
         end else if (r < lf_pct + txt_pct + 8 && clear_ok) begin
            queue_item(CMD_CLEAR, 8'($urandom), 14'($urandom), 1'($urandom));
         end else begin
            queue_item(CMD_READ, 8'($urandom),
                       $urandom_range(0, 1) ? 14'($urandom)
                                            : 14'($urandom_range(0, SCREEN_CELLS + COLUMNS - 1)),
                       1'($urandom));
         end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (command_queue.size() != 0 || start || expected_views.size() != 0 || busy);
   endtask

   task automatic csr_write(input csr_reg_type idx, input logic [CELL_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == REG_ATTR) attr_reg = data[CHAR_W-1:0];
      else blank_reg = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // command driver: holds an item until the transfer, then waits out the next gap
   always @(negedge clock) begin : drive_commands
      logic       hold;
      console_cmd nxt;
      hold = start && !cmd_taken;
      if (!hold) begin
         if (reset || command_queue.size() == 0) begin
            idle_cycles = 0;
            start <= 1'b0;
         end else if (idle_cycles < command_queue[0].gap) begin
            idle_cycles++;
            start <= 1'b0;
         end else begin
            nxt = command_queue.pop_front();
            idle_cycles = 0;
            start <= 1'b1;
            req_command <= nxt.cmd;
            req_char_code <= nxt.ch;
            req_cell_index <= nxt.idx;
            req_end_of_write <= nxt.eow;
         end
      end
   end

   // monitor: checks result strobes, predicts each accepted command
   always @(posedge clock) begin : watch_console
      console_view want;
      if (!reset && rsp_strobe) begin
         if (expected_views.size() == 0) begin
            $error("result strobe with no command outstanding");
            fail_count++;
         end else begin
            want = expected_views.pop_front();
            check_field("cell_data", want.cell_data, rsp_cell_data);
            check_field("cursor_cell", want.cursor_cell, rsp_cursor_cell);
            check_field("display_start", want.display_start, rsp_display_start);
            check_field("cursor_update", want.cursor_update, rsp_cursor_update);
            results_checked++;
         end
      end
      if (!reset && start && !busy) begin
         expected_views.push_back(console_apply(req_command, req_char_code, req_cell_index,
                                                req_end_of_write));
         commands_sent++;
      end
      cmd_taken <= !reset && start && !busy;
   end

   always @(posedge clock) begin : run_limit
      cycle_count++;
      if (cycle_count > cycle_limit) begin
         $error("no progress within %0d cycles, %0d results outstanding",
                cycle_limit, expected_views.size());
         $display("FAIL text_console_char_engine");
         $finish;
      end
   end

   initial begin
      attr_reg = ATTR_RESET;
      blank_reg = BLANK_RESET;
      col = 0;
      row = 0;
      cur_ofs = 0;
      scr_ofs = 0;
      shadow_fill();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, every command, each control byte
      queue_item(CMD_READ, 8'hFF, '0, 1'b1);
      queue_item(CMD_READ, 8'h00, '1, 1'b0);
      queue_item(CMD_PUT, 8'h41, '1, 1'b0);
      queue_item(CMD_PUT, 8'hFF, '0, 1'b1);
      queue_item(CMD_PUT, CH_NUL, 14'($urandom), 1'b1);
      queue_item(CMD_PUT, CH_BEL, 14'($urandom), 1'b0);
      queue_item(CMD_PUT, CH_HT, 14'($urandom), 1'b1);
      queue_item(CMD_PUT, CH_VT, 14'($urandom), 1'b0);
      queue_item(CMD_READ, 8'($urandom), 14'd1, 1'b1);
      queue_item(CMD_PUT, CH_BS, 14'($urandom), 1'b1);
      queue_item(CMD_READ, 8'($urandom), 14'd1, 1'b0);
      queue_item(CMD_PUT, CH_DEL, 14'($urandom), 1'b1);
      queue_item(CMD_PUT, CH_CR, 14'($urandom), 1'b0);
      queue_item(CMD_PUT, CH_BS, 14'($urandom), 1'b1);   // column zero, no effect
      queue_item(CMD_READ, 8'($urandom), 14'd0, 1'b1);
      queue_item(CMD_PUT, 8'h80, 14'($urandom), 1'b1);
      queue_item(CMD_PUT, CH_LF, 14'($urandom), 1'b1);
      queue_item(CMD_PUT, CH_FF, 14'($urandom), 1'b0);
      queue_item(CMD_PUT, 8'h7E, 14'($urandom), 1'b1);
      queue_item(CMD_READ, 8'($urandom), 14'd160, 1'b0);
      queue_item(CMD_UNUSED, 8'hFF, '1, 1'b1);
      queue_item(CMD_CLEAR, 8'h00, '0, 1'b0);
      queue_item(CMD_READ, 8'($urandom), 14'd160, 1'b1);

      wait_idle();
      csr_write(REG_ATTR, 16'hFFFF);
      csr_write(REG_BLANK, 16'hFFFF);
      gen_text(280, 25, 45, 1'b1);

      // line-feed heavy, no clears: runs the screen off the end of the store
      wait_idle();
      csr_write(REG_ATTR, {8'($urandom), 8'h00});
      csr_write(REG_BLANK, 16'h0000);
      gen_text(380, 80, 8, 1'b0);

      wait_idle();
      csr_write(REG_ATTR, 16'($urandom));
      csr_write(REG_BLANK, 16'($urandom));
      gen_text(260, 40, 35, 1'b1);

      wait_idle();
      repeat (COLUMNS + 16) @(posedge clock);
      $display("%0d commands (%0d reads, %0d clears), %0d results checked; %0d scrolls, %0d relocations",
               commands_sent, reads_sent, clears_sent, results_checked, scroll_count,
               relocation_count);
      if (fail_count == 0) begin
         $display("PASS text_console_char_engine");
      end else begin
         $display("FAIL text_console_char_engine");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/tcce_pkg.sv
sv/tcce_cell_ram.sv
sv/tcce_seq.sv
sv/text_console_char_engine.sv
dv/text_console_char_engine_test.sv
